// ===== hdl/urb_pkg.sv =====
// shared types and constants for the uart with receive ring buffer
package urb_pkg;

	localparam int FIFO_DEPTH_DEF = 64;
	localparam logic [15:0] TX_START_EXTRA = 16'd6;

	localparam logic [2:0] OP_IDLE     = 3'd0;
	localparam logic [2:0] OP_WRITE    = 3'd1;
	localparam logic [2:0] OP_READ     = 3'd2;
	localparam logic [2:0] OP_PEEK     = 3'd3;
	localparam logic [2:0] OP_FLUSH    = 3'd4;
	localparam logic [2:0] OP_TAKE_OVF = 3'd5;

	localparam logic [1:0] REG_RX_CENTER = 2'd0;
	localparam logic [1:0] REG_RX_BIT    = 2'd1;
	localparam logic [1:0] REG_RX_STOP   = 2'd2;
	localparam logic [1:0] REG_TX_BIT    = 2'd3;

	typedef enum logic [1:0] {
		RX_IDLE   = 2'd0,
		RX_CENTER = 2'd1,
		RX_DATA   = 2'd2,
		RX_STOP   = 2'd3
	} rx_phase_t;

	typedef enum logic [1:0] {
		TX_IDLE  = 2'd0,
		TX_START = 2'd1,
		TX_DATA  = 2'd2,
		TX_STOP  = 2'd3
	} tx_phase_t;

	typedef struct packed {
		logic [2:0] operation;
		logic       rx_level;
		logic [7:0] tx_byte;
	} urb_in_t;

	typedef struct packed {
		logic       tx_level;
		logic       tx_busy;
		logic       write_accepted;
		logic       data_valid;
		logic [7:0] data_byte;
		logic [7:0] available;
		logic       overflow;
		logic       rx_busy;
	} urb_out_t;

endpackage

// ===== hdl/urb_out_queue.sv =====
// two-entry result queue between the tick pipeline and the output channel
module urb_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  urb_pkg::urb_out_t din,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output urb_pkg::urb_out_t dout
);
	import urb_pkg::*;

	urb_out_t   entry_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign room      = (cnt_q != 2'd2) || pop;
	assign dout      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== hdl/uart_8n1_with_rx_ring_buffer_top.sv =====
// top level: 8n1 uart ticked once per input transfer, receive ring buffer in a memory
// a result is held in the read-stage register, then in the output queue, after its input transfer is taken
// throughput: one tick per clock while in_stall is low; up to three ticks in flight before in_stall rises
// the ring buffer is one memory, one write and one registered read per tick
// reset clears the control state and the registers to zero; buffer contents start undefined
// tx_bit_q of zero refuses writes
module uart_8n1_with_rx_ring_buffer_top #(
	parameter int FIFO_DEPTH = urb_pkg::FIFO_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  urb_pkg::urb_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output urb_pkg::urb_out_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import urb_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int CW = AW + 1;

	logic [15:0] rx_center_q, rx_bit_q, rx_stop_q, tx_bit_q;

	rx_phase_t   rx_phase_q, rx_phase_d;
	logic [15:0] rx_cnt_q, rx_cnt_d;
	logic [2:0]  rx_idx_q, rx_idx_d;
	logic [7:0]  rx_shift_q, rx_shift_d;
	tx_phase_t   tx_phase_q, tx_phase_d;
	logic [15:0] tx_cnt_q, tx_cnt_d;
	logic [2:0]  tx_idx_q, tx_idx_d;
	logic [7:0]  tx_shift_q, tx_shift_d;
	logic [AW-1:0] head_q, head_d, tail_q, tail_d, head_inc, tail_inc;
	logic        ovf_q, ovf_d;

	logic [7:0]  mem [FIFO_DEPTH];
	logic        acc, wr_en, fwd, pop;
	logic [1:0]  occ_q;
	urb_out_t    res;
	logic [CW-1:0] fill;
	logic [16:0] start_sum;

	urb_out_t    res_s1;
	logic        valid_s1, fwd_s1;
	logic [7:0]  fwd_byte_s1, rd_s1;
	urb_out_t    q_din;
	logic        q_push, q_room;
	logic        cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			REG_RX_CENTER: prdata = {16'h0000, rx_center_q};
			REG_RX_BIT:    prdata = {16'h0000, rx_bit_q};
			REG_RX_STOP:   prdata = {16'h0000, rx_stop_q};
			REG_TX_BIT:    prdata = {16'h0000, tx_bit_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_center_q <= '0;
			rx_bit_q    <= '0;
			rx_stop_q   <= '0;
			tx_bit_q    <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_RX_CENTER: rx_center_q <= pwdata[15:0];
				REG_RX_BIT:    rx_bit_q    <= pwdata[15:0];
				REG_RX_STOP:   rx_stop_q   <= pwdata[15:0];
				REG_TX_BIT:    tx_bit_q    <= pwdata[15:0];
			endcase
		end
	end

	// input handshake
	assign pop      = out_valid && !out_stall;
	assign in_stall = (occ_q == 2'd3);
	assign acc      = in_valid && !in_stall;

	assign head_inc  = (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc  = (tail_q == AW'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign start_sum = {1'b0, tx_bit_q} + {1'b0, TX_START_EXTRA};

	// one tick: receiver, then buffer operation, then transmitter
	always_comb begin
		rx_phase_d = rx_phase_q;
		rx_cnt_d   = rx_cnt_q;
		rx_idx_d   = rx_idx_q;
		rx_shift_d = rx_shift_q;
		tx_phase_d = tx_phase_q;
		tx_cnt_d   = tx_cnt_q;
		tx_idx_d   = tx_idx_q;
		tx_shift_d = tx_shift_q;
		head_d     = head_q;
		tail_d     = tail_q;
		ovf_d      = ovf_q;
		wr_en      = 1'b0;
		res        = '0;

		if (rx_phase_q == RX_IDLE) begin
			if (!in_data.rx_level) begin
				rx_phase_d = RX_CENTER;
				rx_cnt_d   = rx_center_q;
			end
		end else if (rx_cnt_q != 16'd0) begin
			rx_cnt_d = rx_cnt_q - 16'd1;
		end else begin
			unique case (rx_phase_q)
				RX_CENTER: begin
					rx_phase_d = RX_DATA;
					rx_idx_d   = 3'd0;
					rx_shift_d = 8'h00;
					rx_cnt_d   = rx_bit_q;
				end
				RX_DATA: begin
					rx_shift_d = rx_shift_q | (8'(in_data.rx_level) << rx_idx_q);
					rx_idx_d   = rx_idx_q + 3'd1;
					if (rx_idx_q == 3'd7) begin
						rx_phase_d = RX_STOP;
						rx_cnt_d   = rx_stop_q;
					end else begin
						rx_cnt_d = rx_bit_q;
					end
				end
				default: begin
					rx_phase_d = RX_IDLE;
					rx_idx_d   = 3'd0;
					if (tail_inc != head_q) begin
						wr_en  = 1'b1;
						tail_d = tail_inc;
					end else begin
						ovf_d = 1'b1;
					end
				end
			endcase
		end

		res.overflow = ovf_d;

		unique case (in_data.operation)
			OP_READ: begin
				if (head_q != tail_d) begin
					res.data_valid = 1'b1;
					head_d         = head_inc;
				end
			end
			OP_PEEK: begin
				res.data_valid = (head_q != tail_d);
			end
			OP_FLUSH: begin
				head_d = '0;
				tail_d = '0;
			end
			OP_TAKE_OVF: begin
				ovf_d = 1'b0;
			end
			default: begin
			end
		endcase

		if (in_data.operation == OP_WRITE && tx_phase_q == TX_IDLE && tx_bit_q != 16'd0) begin
			res.write_accepted = 1'b1;
			tx_phase_d         = TX_START;
			tx_idx_d           = 3'd0;
			tx_shift_d         = in_data.tx_byte;
			tx_cnt_d           = start_sum[16] ? 16'hFFFF : start_sum[15:0];
		end else if (tx_phase_q != TX_IDLE) begin
			if (tx_cnt_q > 16'd1) begin
				tx_cnt_d = tx_cnt_q - 16'd1;
			end else begin
				unique case (tx_phase_q)
					TX_START: begin
						tx_phase_d = TX_DATA;
						tx_idx_d   = 3'd0;
						tx_cnt_d   = tx_bit_q;
					end
					TX_DATA: begin
						tx_idx_d = tx_idx_q + 3'd1;
						if (tx_idx_q == 3'd7) begin
							tx_phase_d = TX_STOP;
						end
						tx_cnt_d = tx_bit_q;
					end
					default: begin
						tx_phase_d = TX_IDLE;
						tx_idx_d   = 3'd0;
						tx_cnt_d   = 16'd0;
					end
				endcase
			end
		end

		if (tail_d >= head_d) begin
			fill = {1'b0, tail_d} - {1'b0, head_d};
		end else begin
			fill = {1'b0, tail_d} + CW'(FIFO_DEPTH) - {1'b0, head_d};
		end

		unique case (tx_phase_d)
			TX_START: res.tx_level = 1'b0;
			TX_DATA:  res.tx_level = tx_shift_d[tx_idx_d];
			default:  res.tx_level = 1'b1;
		endcase
		res.tx_busy   = (tx_phase_d != TX_IDLE);
		res.rx_busy   = (rx_phase_d != RX_IDLE);
		res.available = 8'(fill);
	end

	// pushed byte lands on the entry being read: forward it
	assign fwd = wr_en && (tail_q == head_q);

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= mem[head_q];
			if (wr_en) begin
				mem[tail_q] <= rx_shift_q;
			end
			res_s1      <= res;
			fwd_s1      <= fwd;
			fwd_byte_s1 <= rx_shift_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase_q <= RX_IDLE;
			rx_cnt_q   <= '0;
			rx_idx_q   <= '0;
			rx_shift_q <= '0;
			tx_phase_q <= TX_IDLE;
			tx_cnt_q   <= '0;
			tx_idx_q   <= '0;
			tx_shift_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			ovf_q      <= 1'b0;
			valid_s1   <= 1'b0;
			occ_q      <= 2'd0;
		end else begin
			if (acc) begin
				rx_phase_q <= rx_phase_d;
				rx_cnt_q   <= rx_cnt_d;
				rx_idx_q   <= rx_idx_d;
				rx_shift_q <= rx_shift_d;
				tx_phase_q <= tx_phase_d;
				tx_cnt_q   <= tx_cnt_d;
				tx_idx_q   <= tx_idx_d;
				tx_shift_q <= tx_shift_d;
				head_q     <= head_d;
				tail_q     <= tail_d;
				ovf_q      <= ovf_d;
				valid_s1   <= 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
			occ_q <= occ_q + 2'(acc) - 2'(pop);
		end
	end

	// merge the memory read, or the forwarded byte, into the result; zero when no data is valid
	always_comb begin
		q_din = res_s1;
		if (!res_s1.data_valid) begin
			q_din.data_byte = 8'h00;
		end else if (fwd_s1) begin
			q_din.data_byte = fwd_byte_s1;
		end else begin
			q_din.data_byte = rd_s1;
		end
	end

	assign q_push = valid_s1 && q_room;

	urb_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.din       (q_din),
		.room      (q_room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dout      (out_data)
	);

`ifndef SYNTHESIS
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(head_q) < FIFO_DEPTH) && (int'(tail_q) < FIFO_DEPTH))
		else $error("ring pointer beyond buffer depth");

	a_s1_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> valid_s1)
		else $error("accepted tick did not reach the read stage");

	a_write_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.write_accepted) |-> (out_data.tx_busy && !out_data.tx_level))
		else $error("accepted write without start bit");

	a_empty_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.data_valid) |-> (out_data.data_byte == 8'h00))
		else $error("data byte set without valid data");
`endif

endmodule
